[rtl/aobc_pkg.sv]
// Shared constants and codes for the adaptive offload batch controller.
// No dependencies; used by adaptive_offload_batch_controller.
package aobc_pkg;

	// Field widths
	localparam int TIME_W  = 32;
	localparam int TILE_W  = 12;
	localparam int BATCH_W = 7;
	localparam int NUM_W   = TILE_W + 32;
	localparam int CNT_W   = 6;

	// 0.01 ms in 16.16, lowest divisor
	localparam logic [TIME_W-1:0] FLOOR01 = 32'd655;

	// Item kinds on the tuser lane
	localparam logic [1:0] MODE_ATTACH = 2'd0;
	localparam logic [1:0] MODE_FRAME  = 2'd1;
	localparam logic [1:0] MODE_DETACH = 2'd2;

	// Register indexes
	localparam logic [2:0] REG_ALPHA    = 3'd0;
	localparam logic [2:0] REG_LOW      = 3'd1;
	localparam logic [2:0] REG_HIGH     = 3'd2;
	localparam logic [2:0] REG_STEP     = 3'd3;
	localparam logic [2:0] REG_INIT     = 3'd4;
	localparam logic [2:0] REG_RATIO    = 3'd5;
	localparam logic [2:0] REG_MINFR    = 3'd6;
	localparam logic [2:0] REG_STREAK   = 3'd7;

	// Sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_ADD  = 3'd3;
	localparam logic [2:0] S_THR  = 3'd4;
	localparam logic [2:0] S_CMP  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	// Average that the shared unit is working on
	localparam logic [1:0] T_RATE = 2'd0;
	localparam logic [1:0] T_HYB  = 2'd1;
	localparam logic [1:0] T_CPUO = 2'd2;

	// Result beat
	typedef struct packed {
		logic [TIME_W-1:0]  rate_avg;
		logic [TIME_W-1:0]  cpu_only_avg;
		logic [TIME_W-1:0]  hybrid_avg;
		logic [BATCH_W-1:0] next_batch;
		logic [BATCH_W-1:0] batch_used;
		logic               was_hybrid;
		logic               offload_enabled;
	} result_t;

endpackage

[rtl/adaptive_offload_batch_controller.sv]
// Adaptive offload batch controller: top level with its sequencer, shared divider
// and shared 32x16 multiplier. Depends on aobc_pkg.
//
// Usage:
//  s_* carries one item per beat: tuser holds the mode (attach, frame report,
//  detach), tdata the report fields. m_* returns one result beat per item.
//  cfg_* writes one of eight registers; it is always ready. The user must
//  write it only while the block is idle; the block does not enforce this.
//  Attach, detach, an ignored frame and a hybrid frame with a device failure
//  go straight to the result beat. A CPU-only frame runs one 44-step
//  division and two averages. A hybrid frame runs two divisions, three
//  averages and the slowness check. The next input beat can be taken in the
//  cycle after the result beat has been taken.
//  One item is handled at a time: s_tready is high only when idle, and goes
//  low from acceptance until the result beat has been taken.
//  A stalled receiver holds the result beat in the output register and
//  blocks further input.
//  Reset loads the register defaults and clears all state and averages;
//  the block is ready in the first cycle after reset.
module adaptive_offload_batch_controller (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,   // device_created, tiles[12], cpu_phase_ms[32],
	                                // tail_ms[32], total_ms[32], device_failed, 2 pad
	input  logic [1:0]   s_tuser,   // mode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,   // offload_enabled, was_hybrid, batch_used[7],
	                                // next_batch[7], hybrid_avg_ms, cpu_only_avg_ms,
	                                // cpu_rate_avg
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [16:0]  cfg_data
);

	localparam int TW = aobc_pkg::TIME_W;
	localparam int BW = aobc_pkg::BATCH_W;
	localparam int NW = aobc_pkg::NUM_W;
	localparam int CW = aobc_pkg::CNT_W;

	// Registers
	logic [15:0]   alpha_q;
	logic [BW-1:0] low_q, high_q, init_q;
	logic [3:0]    step_q;
	logic [16:0]   ratio_q;
	logic [7:0]    minfr_q, streak_q;

	// Block state
	logic          attached_q, enabled_q;
	logic [BW-1:0] batch_q;
	logic [7:0]    frames_q, slow_q;
	logic [TW-1:0] rate_q, hyb_q, cpuo_q;

	// Sequencer
	logic [2:0]    state_q;
	logic [1:0]    tgt_q;
	logic          hybrid_q;
	logic [BW-1:0] used_q;
	logic [aobc_pkg::TILE_W-1:0] tiles_q;
	logic [TW-1:0] cpu_q, tail_q, total_q;
	logic [TW-1:0] v_q;

	// Divider
	logic [NW-1:0]  num_q;
	logic [TW:0]    rem_q;
	logic [TW-1:0]  dvs_q;
	logic [CW-1:0]  cnt_q;

	// Multiplier
	logic [47:0]    prod_q;
	logic           ge_q;

	logic [1:0]    in_mode;
	logic          in_dev, in_fail;
	logic [aobc_pkg::TILE_W-1:0] in_tiles;
	logic [TW-1:0] in_cpu, in_tail, in_total;

	assign in_mode  = s_tuser;
	assign in_dev   = s_tdata[0];
	assign in_tiles = s_tdata[12:1];
	assign in_cpu   = s_tdata[44:13];
	assign in_tail  = s_tdata[76:45];
	assign in_total = s_tdata[108:77];
	assign in_fail  = s_tdata[109];

	assign s_tready  = (state_q == aobc_pkg::S_IDLE);
	assign cfg_ready = 1'b1;

	// Hybrid decision and batch clamp on the incoming item
	logic          is_hyb;
	logic [BW-1:0] bc0, bc1, b_in;
	logic [aobc_pkg::TILE_W:0] lim;
	always_comb begin
		is_hyb = enabled_q && attached_q && (in_tiles >= {4'b0, low_q, 1'b0});
		bc0    = (batch_q < low_q) ? low_q : batch_q;
		bc1    = (bc0 > high_q) ? high_q : bc0;
		lim    = {1'b0, in_tiles} - {6'b0, low_q};
		b_in   = ({6'b0, bc1} > lim) ? lim[BW-1:0] : bc1;
	end

	// Divider step
	logic [TW:0]   rem_sh;
	logic          qbit;
	logic [NW-1:0] num_nx;
	logic [TW-1:0] quot;
	always_comb begin
		rem_sh = {rem_q[TW-1:0], num_q[NW-1]};
		qbit   = (rem_sh >= {1'b0, dvs_q});
		num_nx = {num_q[NW-2:0], qbit};
		quot   = (num_nx[NW-1:TW] != '0) ? '1 : num_nx[TW-1:0];
	end

	// Shared multiplier and average update
	logic [TW-1:0] old_v, diff, mul_a, avg_nx;
	logic [15:0]   mul_b;
	logic [TW:0]   thr;
	always_comb begin
		case (tgt_q)
			aobc_pkg::T_RATE: old_v = rate_q;
			aobc_pkg::T_HYB:  old_v = hyb_q;
			default:          old_v = cpuo_q;
		endcase
		diff  = (v_q >= old_v) ? (v_q - old_v) : (old_v - v_q);
		mul_a = (state_q == aobc_pkg::S_THR) ? cpuo_q : diff;
		mul_b = (state_q == aobc_pkg::S_THR) ? ratio_q[15:0] : alpha_q;
		avg_nx = ge_q ? (old_v + prod_q[47:16]) : (old_v - prod_q[47:16]);
		thr   = (ratio_q[16] ? {1'b0, cpuo_q} : '0) + {1'b0, prod_q[47:16]};
	end

	// Batch adjustment from the tail against the CPU phase
	logic signed [8:0] bn, bl;
	logic [BW-1:0]     b_new;
	always_comb begin
		if ({tail_q, 2'b00} < {2'b00, cpu_q})
			bn = $signed({2'b0, used_q}) + $signed({5'b0, step_q});
		else if (tail_q > cpu_q)
			bn = $signed({2'b0, used_q}) - $signed({5'b0, step_q});
		else
			bn = $signed({2'b0, used_q});
		bl    = (bn < $signed({2'b0, low_q})) ? $signed({2'b0, low_q}) : bn;
		b_new = (bl > $signed({2'b0, high_q})) ? high_q : bl[BW-1:0];
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= 16'd9830;
			low_q    <= 7'd4;
			high_q   <= 7'd16;
			step_q   <= 4'd2;
			init_q   <= 7'd8;
			ratio_q  <= 17'd68813;
			minfr_q  <= 8'd5;
			streak_q <= 8'd3;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				aobc_pkg::REG_ALPHA:  alpha_q  <= cfg_data[15:0];
				aobc_pkg::REG_LOW:    low_q    <= cfg_data[6:0];
				aobc_pkg::REG_HIGH:   high_q   <= cfg_data[6:0];
				aobc_pkg::REG_STEP:   step_q   <= cfg_data[3:0];
				aobc_pkg::REG_INIT:   init_q   <= cfg_data[6:0];
				aobc_pkg::REG_RATIO:  ratio_q  <= cfg_data;
				aobc_pkg::REG_MINFR:  minfr_q  <= cfg_data[7:0];
				aobc_pkg::REG_STREAK: streak_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= aobc_pkg::S_IDLE;
			tgt_q      <= aobc_pkg::T_RATE;
			hybrid_q   <= 1'b0;
			used_q     <= '0;
			attached_q <= 1'b0;
			enabled_q  <= 1'b0;
			batch_q    <= '0;
			frames_q   <= '0;
			slow_q     <= '0;
			rate_q     <= '0;
			hyb_q      <= '0;
			cpuo_q     <= '0;
			cnt_q      <= '0;
			tiles_q    <= '0;
			cpu_q      <= '0;
			tail_q     <= '0;
			total_q    <= '0;
			v_q        <= '0;
			num_q      <= '0;
			rem_q      <= '0;
			dvs_q      <= aobc_pkg::FLOOR01;
			prod_q     <= '0;
			ge_q       <= 1'b0;
		end else begin
			unique case (state_q)
				aobc_pkg::S_IDLE: begin
					if (s_tvalid) begin
						tiles_q  <= in_tiles;
						cpu_q    <= in_cpu;
						tail_q   <= in_tail;
						total_q  <= in_total;
						hybrid_q <= 1'b0;
						used_q   <= '0;
						tgt_q    <= aobc_pkg::T_RATE;
						state_q  <= aobc_pkg::S_OUT;
						if (in_mode == aobc_pkg::MODE_ATTACH) begin
							if (!attached_q) begin
								attached_q <= in_dev;
								enabled_q  <= in_dev;
								batch_q    <= init_q;
							end
						end else if (in_mode == aobc_pkg::MODE_DETACH) begin
							attached_q <= 1'b0;
							enabled_q  <= 1'b0;
						end else if (in_mode == aobc_pkg::MODE_FRAME && in_tiles != '0) begin
							// start the rate division
							rem_q   <= '0;
							cnt_q   <= '0;
							dvs_q   <= (in_cpu < aobc_pkg::FLOOR01) ? aobc_pkg::FLOOR01
							                                         : in_cpu;
							hybrid_q <= is_hyb;
							if (is_hyb) begin
								used_q <= b_in;
								num_q  <= {in_tiles - {5'b0, b_in}, 32'b0};
								if (in_fail) enabled_q <= 1'b0;
								else state_q <= aobc_pkg::S_DIV;
							end else begin
								num_q   <= {in_tiles, 32'b0};
								state_q <= aobc_pkg::S_DIV;
							end
						end
					end
				end
				aobc_pkg::S_DIV: begin
					rem_q <= qbit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
					num_q <= num_nx;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(NW - 1)) begin
						v_q     <= quot;
						cnt_q   <= '0;
						state_q <= aobc_pkg::S_MUL;
					end
				end
				aobc_pkg::S_MUL: begin
					prod_q  <= {16'b0, mul_a} * {32'b0, mul_b};
					ge_q    <= (v_q >= old_v);
					state_q <= aobc_pkg::S_ADD;
				end
				aobc_pkg::S_ADD: begin
					case (tgt_q)
						aobc_pkg::T_RATE: begin
							rate_q <= avg_nx;
							if (hybrid_q) begin
								batch_q  <= b_new;
								if (frames_q != 8'hFF) frames_q <= frames_q + 1'b1;
								v_q   <= total_q;
								tgt_q <= aobc_pkg::T_HYB;
							end else begin
								v_q   <= cpu_q;
								tgt_q <= aobc_pkg::T_CPUO;
							end
							state_q <= aobc_pkg::S_MUL;
						end
						aobc_pkg::T_HYB: begin
							// projected CPU-only time: tiles over the new rate
							hyb_q   <= avg_nx;
							num_q   <= {tiles_q, 32'b0};
							rem_q   <= '0;
							dvs_q   <= (rate_q < aobc_pkg::FLOOR01) ? aobc_pkg::FLOOR01
							                                         : rate_q;
							tgt_q   <= aobc_pkg::T_CPUO;
							state_q <= aobc_pkg::S_DIV;
						end
						default: begin
							cpuo_q  <= avg_nx;
							state_q <= hybrid_q ? aobc_pkg::S_THR : aobc_pkg::S_OUT;
						end
					endcase
				end
				aobc_pkg::S_THR: begin
					prod_q  <= {16'b0, mul_a} * {32'b0, mul_b};
					state_q <= aobc_pkg::S_CMP;
				end
				aobc_pkg::S_CMP: begin
					// count slow frames and drop offload on a long streak
					if ({1'b0, hyb_q} > thr) begin
						if (slow_q != 8'hFF) slow_q <= slow_q + 1'b1;
						if (frames_q >= minfr_q && (slow_q + 9'd1) >= {1'b0, streak_q})
							enabled_q <= 1'b0;
					end else begin
						slow_q <= '0;
						if (frames_q >= minfr_q && streak_q == 8'd0) enabled_q <= 1'b0;
					end
					state_q <= aobc_pkg::S_OUT;
				end
				aobc_pkg::S_OUT: begin
					if (m_tready) state_q <= aobc_pkg::S_IDLE;
				end
				default: state_q <= aobc_pkg::S_IDLE;
			endcase
		end
	end

	// Result beat
	aobc_pkg::result_t res;
	always_comb begin
		res.offload_enabled = enabled_q;
		res.was_hybrid      = hybrid_q;
		res.batch_used      = used_q;
		res.next_batch      = batch_q;
		res.hybrid_avg      = hyb_q;
		res.cpu_only_avg    = cpuo_q;
		res.rate_avg        = rate_q;
	end
	assign m_tvalid = (state_q == aobc_pkg::S_OUT);
	assign m_tdata  = res;

	// Checks
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("input ready while result pending");
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != aobc_pkg::S_DIV) |-> (cnt_q == '0)) else $error("divider count stray");
	a_used: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !hybrid_q) |-> (used_q == '0)) else $error("batch on CPU-only frame");
	a_div_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aobc_pkg::S_DIV) |-> (dvs_q >= aobc_pkg::FLOOR01))
		else $error("divisor below floor");

endmodule
